[hdl/majority_vote_with_verify_top_assert.svh]
// Assertion macros shared by the majority vote block.
`ifndef MAJORITY_VOTE_WITH_VERIFY_TOP_ASSERT_SVH
`define MAJORITY_VOTE_WITH_VERIFY_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MVV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MVV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mvv_pkg.sv]
// Constants and types for the majority vote block.
package mvv_pkg;
    localparam int MAX_ITEMS = 1024;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam logic [CNT_W-1:0]  MAX_CNT     = CNT_W'(MAX_ITEMS);
    localparam logic [DATA_W-1:0] NO_MAJORITY = '1;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
endpackage

[hdl/majority_vote_with_verify_top.sv]
// Majority vote with a verification walk over the stored set.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | i_valid / o_ready   | i_value, i_last
//  out     | output    | o_valid / i_ready   | o_majority, o_found, o_overflow
//
// One beat is taken per cycle while loading; each stored value goes to the value RAM.
// After the beat marked last, the walk reads the RAM one entry a cycle, bounded by the
// single RAM read port; it holds its end longer while the previous result still waits.
// No input beat is taken during the walk; a new set loads while the result waits.
// Reset is synchronous and clears the control state; the RAM is not cleared.
`include "majority_vote_with_verify_top_assert.svh"

module majority_vote_with_verify_top import mvv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_majority,
    output logic                     o_found,
    output logic                     o_overflow
);

    typedef enum logic {ST_LOAD, ST_WALK} t_state;

    t_state r_state;
    t_data  r_cand;
    t_cnt   r_vote_cnt;
    t_cnt   r_item_cnt;
    t_cnt   r_match_cnt;
    t_cnt   r_walk_idx;
    logic   r_dropped;
    logic   r_rd_pend;
    t_data  r_rd_data;
    logic   r_out_valid;
    t_data  r_out_majority;
    logic   r_out_found;
    logic   r_out_overflow;

    t_data  mem [MAX_ITEMS];

    logic   in_acc;
    logic   wr_en;
    logic   rd_en;
    logic   walk_done;
    logic   out_free;
    t_data  in_data;

    assign o_ready   = (r_state == ST_LOAD);
    assign in_acc    = i_valid && o_ready;
    assign in_data   = t_data'(i_value);
    assign wr_en     = in_acc && (r_item_cnt != MAX_CNT);
    assign rd_en     = (r_state == ST_WALK) && (r_walk_idx != r_item_cnt);
    assign walk_done = (r_state == ST_WALK) && (r_walk_idx == r_item_cnt) && !r_rd_pend;
    assign out_free  = !r_out_valid || i_ready;

    // Value RAM: one write port during loading, one registered read port for the walk.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_item_cnt[ADDR_W-1:0]] <= in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_walk_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cand      <= '0;
            r_vote_cnt  <= '0;
            r_item_cnt  <= '0;
            r_match_cnt <= '0;
            r_walk_idx  <= '0;
            r_dropped   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (walk_done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (wr_en) begin
                            r_item_cnt <= r_item_cnt + 1'b1;
                            if (r_vote_cnt == '0) begin
                                r_cand     <= in_data;
                                r_vote_cnt <= t_cnt'(1);
                            end else if (r_cand == in_data) begin
                                r_vote_cnt <= r_vote_cnt + 1'b1;
                            end else begin
                                r_vote_cnt <= r_vote_cnt - 1'b1;
                            end
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last) begin
                            r_state     <= ST_WALK;
                            r_walk_idx  <= '0;
                            r_match_cnt <= '0;
                            r_rd_pend   <= 1'b0;
                        end
                    end
                end
                ST_WALK: begin
                    r_rd_pend <= rd_en;
                    if (rd_en) begin
                        r_walk_idx <= r_walk_idx + 1'b1;
                    end
                    if (r_rd_pend && (r_rd_data == r_cand)) begin
                        r_match_cnt <= r_match_cnt + 1'b1;
                    end
                    // The result leaves only when the output register is free.
                    if (walk_done && out_free) begin
                        r_out_found    <= (r_match_cnt > (r_item_cnt >> 1));
                        r_out_majority <= (r_match_cnt > (r_item_cnt >> 1)) ? r_cand
                                                                            : NO_MAJORITY;
                        r_out_overflow <= r_dropped;
                        r_cand         <= '0;
                        r_vote_cnt     <= '0;
                        r_item_cnt     <= '0;
                        r_match_cnt    <= '0;
                        r_walk_idx     <= '0;
                        r_dropped      <= 1'b0;
                        r_state        <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_majority = $signed(r_out_majority);
    assign o_found    = r_out_found;
    assign o_overflow = r_out_overflow;

    `MVV_ASSERT_SAME(a_item_bound, 1'b1, r_item_cnt <= MAX_CNT, "item count beyond capacity")
    `MVV_ASSERT_SAME(a_vote_bound, 1'b1, r_vote_cnt <= r_item_cnt, "vote count exceeds items")
    `MVV_ASSERT_SAME(a_match_bound, 1'b1, r_match_cnt <= r_walk_idx,
        "more matches than entries read")
    `MVV_ASSERT_SAME(a_no_major, o_valid && !o_found, o_majority == $signed(NO_MAJORITY),
        "result without majority must carry -1")
    `MVV_ASSERT_NEXT(a_rd_follow, rd_en, r_rd_pend && (r_state == ST_WALK),
        "walk read not followed by its compare")

endmodule
